FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the permutation sign unit RTL.
// Depends on nothing; every macro samples on clock and is disabled by reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an implication holds at every rising clock edge out of reset.
`define OSPS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define OSPS_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error(msg);

`endif

FILE: rtl/core/osps_pkg.sv
// Shared constants and types of the occupied site permutation sign unit.
// Depends on nothing; used by every module under rtl/core.
`timescale 1ns / 1ps
`default_nettype none

package osps_pkg;

   localparam int N_SITES_DEFAULT = 32;
   localparam int MAX_SITES       = 32;
   localparam int MAP_WORDS       = 4;
   localparam int MAP_WORD_W      = 64;
   localparam int IMAGE_W         = 8;
   localparam int SITES_PER_WORD  = MAP_WORD_W / IMAGE_W;
   localparam int CSR_INDEX_W     = 3;
   localparam int REQ_TDATA_W     = 32;
   localparam int RSP_TDATA_W     = 8;

   localparam logic [CSR_INDEX_W-1:0] REG_MAP_WORD_0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MAP_WORD_1 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MAP_WORD_2 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_MAP_WORD_3 = 3'd3;

   typedef logic [MAP_WORDS-1:0][MAP_WORD_W-1:0] map_bank_type;

   // Handshake control produced by the merge stage for the request side.
   typedef struct packed {
      logic req_tready;
      logic lane_load;
   } pipe_ctl_type;

   // Image byte of one site out of the map bank.
   function automatic logic [IMAGE_W-1:0] site_image(input map_bank_type bank,
                                                     input logic [4:0] site);
      logic [1:0] word;
      logic [2:0] slot;
      begin
         word = site[4:3];
         slot = site[2:0];
         site_image = bank[word][slot*IMAGE_W +: IMAGE_W];
      end
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/osps_pair_table.sv
// Map registers and the registered pair inversion flags derived from them.
// Depends on osps_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module osps_pair_table #(
   parameter int N_SITES = osps_pkg::N_SITES_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_we,
   input  wire logic [osps_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire logic [osps_pkg::MAP_WORD_W-1:0]        csr_wdata,
   output logic [N_SITES-1:0][N_SITES-1:0]             pair_flag_ff,
   output logic                                        table_busy
);

   osps_pkg::map_bank_type              map_ff, map_in;
   logic [N_SITES-1:0][N_SITES-1:0]     pair_flag_in;
   logic                                busy_ff;

   always_comb begin
      map_in = map_ff;
      if (csr_we) begin
         unique case (csr_index)
            osps_pkg::REG_MAP_WORD_0: map_in[0] = csr_wdata;
            osps_pkg::REG_MAP_WORD_1: map_in[1] = csr_wdata;
            osps_pkg::REG_MAP_WORD_2: map_in[2] = csr_wdata;
            osps_pkg::REG_MAP_WORD_3: map_in[3] = csr_wdata;
            default: map_in = map_ff;
         endcase
      end
   end

   // Flag (i, j) set when site i precedes site j but maps above it.
   for (genvar i = 0; i < N_SITES; i++) begin : g_row
      for (genvar j = 0; j < N_SITES; j++) begin : g_col
         if (j > i) begin : g_upper
            assign pair_flag_in[i][j] =
               osps_pkg::site_image(map_ff, 5'(i)) > osps_pkg::site_image(map_ff, 5'(j));
         end else begin : g_lower
            assign pair_flag_in[i][j] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff       <= '0;
         pair_flag_ff <= '0;
         busy_ff      <= 1'b0;
      end else begin
         map_ff       <= map_in;
         pair_flag_ff <= pair_flag_in;
         busy_ff      <= csr_we;
      end
   end

   // Hold requests off for the cycle in which the flags catch up.
   assign table_busy = busy_ff;

   `OSPS_ASSERT_NEXT(a_busy_after_write, clock, reset, csr_we, table_busy,
                     "pair table not marked busy after a map write")

endmodule

`default_nettype wire

FILE: rtl/core/osps_lane.sv
// One lane: parity of the inversions that one occupied site forms with later sites.
// Depends on osps_pkg for the default site count.
`timescale 1ns / 1ps
`default_nettype none

module osps_lane #(
   parameter int N_SITES = osps_pkg::N_SITES_DEFAULT,
   parameter int LANE    = 0
) (
   input  wire logic                clock,
   input  wire logic                load,
   input  wire logic [N_SITES-1:0]  occupancy,
   input  wire logic [N_SITES-1:0]  flag_row,
   output logic                     parity_ff
);

   logic parity_in;

   // Flags below and on the diagonal are zero, so only later sites count.
   assign parity_in = occupancy[LANE] & (^(occupancy & flag_row));

   always_ff @(posedge clock) begin
      if (load) begin
         parity_ff <= parity_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/osps_merge.sv
// Merge stage: XOR of the lane parities, output register and pipeline handshake.
// Depends on osps_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module osps_merge #(
   parameter int N_SITES = osps_pkg::N_SITES_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   input  wire logic                 table_busy,
   input  wire logic [N_SITES-1:0]   lane_bits,
   output osps_pkg::pipe_ctl_type    pipe_ctl,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic                      rsp_sign
);

   logic lane_v_ff, lane_v_in;
   logic out_v_ff, out_v_in;
   logic sign_ff, sign_in;
   logic advance;

   assign advance             = lane_v_ff & (~out_v_ff | rsp_tready);
   assign pipe_ctl.req_tready = (~lane_v_ff | advance) & ~table_busy;
   assign pipe_ctl.lane_load  = req_tvalid & pipe_ctl.req_tready;

   always_comb begin
      priority if (pipe_ctl.lane_load) begin
         lane_v_in = 1'b1;
      end else if (advance) begin
         lane_v_in = 1'b0;
      end else begin
         lane_v_in = lane_v_ff;
      end
      priority if (advance) begin
         out_v_in = 1'b1;
      end else if (rsp_tready) begin
         out_v_in = 1'b0;
      end else begin
         out_v_in = out_v_ff;
      end
      sign_in = advance ? ^lane_bits : sign_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         lane_v_ff <= lane_v_in;
         out_v_ff  <= out_v_in;
      end
      sign_ff <= sign_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_sign   = sign_ff;

   `OSPS_ASSERT_NEXT(a_load_fills_lanes, clock, reset, pipe_ctl.lane_load, lane_v_ff,
                     "accepted request did not reach the lane stage")
   `OSPS_ASSERT_NEXT(a_lanes_hold_on_stall, clock, reset,
                     lane_v_ff && out_v_ff && !rsp_tready, lane_v_ff,
                     "lane stage dropped a request while the output stalled")
   `OSPS_ASSERT_NEXT(a_advance_fills_output, clock, reset, advance, out_v_ff,
                     "lane result did not reach the output register")

endmodule

`default_nettype wire

FILE: rtl/core/occupied_site_permutation_sign_unit.sv
// Top level of the occupied site permutation sign unit.
// Depends on osps_pkg, osps_pair_table, osps_lane, osps_merge and assert_macros.svh.
//
//   channel   direction  handshake            payload
//   req_      in         req_tvalid/tready    req_tdata[31:0]  occupancy
//   rsp_      out        rsp_tvalid/tready    rsp_tdata[0]     sign_negative
//   csr_      in         csr_we               csr_index, csr_wdata (map word)
//
// One request per cycle while the output does not stall and no map write is pending;
// the sign passes the lane register, then the merge/output register. Map writes
// take effect once the map register and then the pair flag registers reload;
// req_tready is low while the flags catch up. Reset clears the map to zero and empties
// the pipeline. A stalled output holds the lane stage, which still accepts while empty.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module occupied_site_permutation_sign_unit #(
   parameter int N_SITES = osps_pkg::N_SITES_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [osps_pkg::REQ_TDATA_W-1:0]    req_tdata,  // [31:0] occupancy
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [osps_pkg::RSP_TDATA_W-1:0]         rsp_tdata,  // [0] sign_negative
   input  wire logic                                csr_we,
   input  wire logic [osps_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [osps_pkg::MAP_WORD_W-1:0]     csr_wdata
);

   logic [N_SITES-1:0][N_SITES-1:0]  pair_flag;
   logic                             table_busy;
   logic [N_SITES-1:0]               occupancy;
   logic [N_SITES-1:0]               lane_bits;
   osps_pkg::pipe_ctl_type           pipe_ctl;
   logic                             rsp_sign;

   // Drop occupancy bits of sites beyond N_SITES.
   assign occupancy = req_tdata[N_SITES-1:0];

   osps_pair_table #(.N_SITES(N_SITES)) u_pair_table (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .pair_flag_ff (pair_flag),
      .table_busy   (table_busy)
   );

   for (genvar i = 0; i < N_SITES; i++) begin : g_lane
      osps_lane #(.N_SITES(N_SITES), .LANE(i)) u_lane (
         .clock     (clock),
         .load      (pipe_ctl.lane_load),
         .occupancy (occupancy),
         .flag_row  (pair_flag[i]),
         .parity_ff (lane_bits[i])
      );
   end

   osps_merge #(.N_SITES(N_SITES)) u_merge (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .table_busy (table_busy),
      .lane_bits  (lane_bits),
      .pipe_ctl   (pipe_ctl),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_sign   (rsp_sign)
   );

   assign req_tready = pipe_ctl.req_tready;
   assign rsp_tdata  = {{(osps_pkg::RSP_TDATA_W-1){1'b0}}, rsp_sign};

   `OSPS_ASSERT(a_no_accept_while_busy, clock, reset, table_busy |-> !req_tready,
                "request accepted while pair flags were reloading")

endmodule

`default_nettype wire
